/* src/olids_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the ordered list block.
// Used by the interfaces, the front, the queue and the back.
package olids_pkg;

    localparam logic [2:0] KIND_CLEAR  = 3'd0;
    localparam logic [2:0] KIND_INSERT = 3'd1;
    localparam logic [2:0] KIND_DELETE = 3'd2;
    localparam logic [2:0] KIND_SEARCH = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_INSERT,
        OP_DELETE,
        OP_SEARCH,
        OP_READ,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_req;

    function automatic t_op decode_kind(input logic [2:0] kind);
        t_op op;
        unique case (kind)
            KIND_CLEAR:  op = OP_CLEAR;
            KIND_INSERT: op = OP_INSERT;
            KIND_DELETE: op = OP_DELETE;
            KIND_SEARCH: op = OP_SEARCH;
            KIND_READ:   op = OP_READ;
            default:     op = OP_NOP;
        endcase
        return op;
    endfunction

endpackage

/* src/olids_if.sv */
`timescale 1ns / 1ps
// Handshake channels of the ordered list block: request words in,
// decoded words between front and back, result words out. Uses olids_pkg.
interface olids_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [7:0]         position;

    modport source (output valid, kind, value, position, input ready);
    modport sink (input valid, kind, value, position, output ready);
endinterface

interface olids_req_if;
    logic             valid;
    logic             ready;
    olids_pkg::t_req  req;

    modport source (output valid, req, input ready);
    modport sink (input valid, req, output ready);
endinterface

interface olids_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] data;
    logic [7:0]         found_position;
    logic [7:0]         count;

    modport source (output valid, status, data, found_position, count, input ready);
    modport sink (input valid, status, data, found_position, count, output ready);
endinterface

/* src/olids_front.sv */
`timescale 1ns / 1ps
// Front of the ordered list block: accepts request words and decodes the kind.
// Depends on olids_pkg and olids_if.
module olids_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    olids_in_if.sink     i_in,
    olids_req_if.source  o_req
);

    logic            r_vld;
    olids_pkg::t_req r_req;
    logic            w_take;

    assign i_in.ready = !r_vld || o_req.ready;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (o_req.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req.op       <= olids_pkg::decode_kind(i_in.kind);
            r_req.value    <= i_in.value;
            r_req.position <= i_in.position;
        end
    end

    assign o_req.valid = r_vld;
    assign o_req.req   = r_req;

endmodule

/* src/olids_queue.sv */
`timescale 1ns / 1ps
// Short queue of decoded words between front and back.
// Depends on olids_pkg and olids_if.
module olids_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    olids_req_if.sink    i_req,
    olids_req_if.source  o_req
);

    localparam int PW = $clog2(olids_pkg::QUEUE_DEPTH);
    localparam int FW = $clog2(olids_pkg::QUEUE_DEPTH + 1);

    olids_pkg::t_req r_slot [olids_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [FW-1:0]   r_fill;
    logic            w_push;
    logic            w_pop;

    assign i_req.ready = (r_fill != FW'(olids_pkg::QUEUE_DEPTH));
    assign o_req.valid = (r_fill != '0);
    assign o_req.req   = r_slot[r_rp];
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = o_req.valid && o_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(olids_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(olids_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + FW'(1);
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_req.req;
        end
    end

endmodule

/* src/olids_back.sv */
`timescale 1ns / 1ps
// Back of the ordered list block: entry memory, count, shift and search walks,
// result register. Depends on olids_pkg and olids_if.
module olids_back #(
    parameter int CAPACITY = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    olids_req_if.sink    i_req,
    olids_out_if.source  o_res
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_RD,
        S_SRCH,
        S_OUT
    } t_state;

    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_mem_q;

    t_state             r_state;
    olids_pkg::t_op     r_op;
    logic signed [31:0] r_value;
    logic [AW-1:0]      r_pidx;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_left;
    logic [AW-1:0]      r_ra;
    logic [AW-1:0]      r_wa;
    logic               r_rv;
    logic               r_first;
    olids_pkg::t_status r_status;
    logic signed [31:0] r_data;
    logic [7:0]         r_fpos;

    logic               w_we;
    logic [AW-1:0]      w_wa;
    logic signed [31:0] w_wd;
    logic [CMPW-1:0]    w_pe;
    logic [CMPW-1:0]    w_ce;
    logic [CW-1:0]      w_hit_pos;
    olids_pkg::t_req    w_req;

    assign w_req       = i_req.req;
    assign w_pe        = CMPW'(w_req.position);
    assign w_ce        = CMPW'(r_count);
    assign w_hit_pos   = CW'(r_wa) + CW'(1);
    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        w_we = 1'b0;
        w_wa = r_wa;
        w_wd = r_mem_q;
        unique case (r_state)
            S_INS: begin
                if (r_rv) begin
                    w_we = 1'b1;
                end else if (r_left == '0) begin
                    w_we = 1'b1;
                    w_wa = r_pidx;
                    w_wd = r_value;
                end
            end
            S_RD: begin
                w_we = r_rv && !r_first;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_mem_q <= r_mem[r_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rv    <= 1'b0;
            r_first <= 1'b0;
            r_left  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op     <= w_req.op;
                        r_value  <= w_req.value;
                        r_pidx   <= AW'(w_pe - CMPW'(1));
                        r_rv     <= 1'b0;
                        r_first  <= 1'b1;
                        r_data   <= '0;
                        r_fpos   <= '0;
                        r_status <= olids_pkg::ST_OK;
                        r_state  <= S_OUT;
                        unique case (w_req.op)
                            olids_pkg::OP_CLEAR: begin
                                r_count <= '0;
                            end
                            olids_pkg::OP_INSERT: begin
                                priority if (w_ce >= CMPW'(CAPACITY)) begin
                                    r_status <= olids_pkg::ST_FULL;
                                end else if (w_pe == '0 || w_pe > w_ce + CMPW'(1)) begin
                                    r_status <= olids_pkg::ST_BADPOS;
                                end else begin
                                    r_left  <= CW'(w_ce - w_pe + CMPW'(1));
                                    r_ra    <= AW'(w_ce - CMPW'(1));
                                    r_state <= S_INS;
                                end
                            end
                            olids_pkg::OP_DELETE, olids_pkg::OP_READ: begin
                                priority if (r_count == '0) begin
                                    r_status <= olids_pkg::ST_EMPTY;
                                end else if (w_pe == '0 || w_pe > w_ce) begin
                                    r_status <= olids_pkg::ST_BADPOS;
                                end else begin
                                    r_left  <= (w_req.op == olids_pkg::OP_READ)
                                               ? CW'(1) : CW'(w_ce - w_pe + CMPW'(1));
                                    r_ra    <= AW'(w_pe - CMPW'(1));
                                    r_state <= S_RD;
                                end
                            end
                            olids_pkg::OP_SEARCH: begin
                                if (r_count == '0) begin
                                    r_status <= olids_pkg::ST_EMPTY;
                                end else begin
                                    r_left  <= r_count;
                                    r_ra    <= '0;
                                    r_state <= S_SRCH;
                                end
                            end
                            default: begin
                                r_status <= olids_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_INS: begin
                    // walk down from the tail, one entry a cycle
                    if (r_left != '0) begin
                        r_rv   <= 1'b1;
                        r_wa   <= r_ra + AW'(1);
                        r_ra   <= r_ra - AW'(1);
                        r_left <= r_left - CW'(1);
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_left == '0 && !r_rv) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_RD: begin
                    // first word read is the result; on a delete the rest move one place down
                    if (r_left != '0) begin
                        r_rv   <= 1'b1;
                        r_wa   <= r_ra - AW'(1);
                        r_ra   <= r_ra + AW'(1);
                        r_left <= r_left - CW'(1);
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_rv && r_first) begin
                        r_data  <= r_mem_q;
                        r_first <= 1'b0;
                    end
                    if (r_left == '0 && !r_rv) begin
                        if (r_op == olids_pkg::OP_DELETE) begin
                            r_count <= r_count - CW'(1);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_SRCH: begin
                    if (r_left != '0) begin
                        r_rv   <= 1'b1;
                        r_wa   <= r_ra;
                        r_ra   <= r_ra + AW'(1);
                        r_left <= r_left - CW'(1);
                    end else begin
                        r_rv <= 1'b0;
                    end
                    priority if (r_rv && r_mem_q == r_value) begin
                        r_fpos   <= 8'(w_hit_pos);
                        r_status <= olids_pkg::ST_OK;
                        r_state  <= S_OUT;
                    end else if (r_left == '0 && !r_rv) begin
                        r_status <= olids_pkg::ST_NOTFOUND;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid          = (r_state == S_OUT);
    assign o_res.status         = r_status;
    assign o_res.data           = r_data;
    assign o_res.found_position = r_fpos;
    assign o_res.count          = 8'(r_count);

endmodule

/* src/ordered_list_insert_delete_search_top.sv */
`timescale 1ns / 1ps
// Top level of the ordered list block: front, queue and back.
// Depends on olids_pkg, olids_if, olids_front, olids_queue and olids_back.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit words in a simple
// dual-port memory (one write, one registered read a cycle). Request words pass a
// decode register and a two-word queue, so new requests are taken while the
// back is busy or a result waits. In the back, clear, unused kinds and rejected
// requests go straight to the output register. Read, insert, delete and search
// walk the entry memory, one entry a cycle: insert moves the entries from the
// tail down to position p one place up, delete moves those after p one place
// down, read fetches the one entry, and search stops at the first match. Each
// result also stays in the output register until taken.
module ordered_list_insert_delete_search_top #(
    parameter int CAPACITY = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    olids_in_if.sink     i_in,
    olids_out_if.source  o_res
);

    olids_req_if w_front_req ();
    olids_req_if w_back_req ();

    olids_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_req   (w_front_req)
    );

    olids_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_front_req),
        .o_req   (w_back_req)
    );

    olids_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_back_req),
        .o_res   (o_res)
    );

    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == olids_pkg::ST_FULL)
        |-> (o_res.count == 8'(CAPACITY)))
        else $error("full status with a count other than capacity");

    a_found_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.found_position != 8'd0)
        |-> (o_res.status == olids_pkg::ST_OK && o_res.data == 32'sd0))
        else $error("match position with bad status or data");

    a_empty_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == olids_pkg::ST_EMPTY)
        |-> (o_res.count == 8'd0 && o_res.data == 32'sd0
             && o_res.found_position == 8'd0))
        else $error("empty status on a non-empty list");

endmodule

/* verif/ordered_list_insert_delete_search_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for ordered_list_insert_delete_search_top: a directed table, a fill
// to capacity, then random bursts, scored against a shadow list kept in the bench (fixed
// rows against the table). Depends on olids_pkg, olids_if and the block under test.
module ordered_list_insert_delete_search_top_test;
    import olids_pkg::*;

    localparam int CAPACITY      = 128;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_WORDS  = 800;
    localparam int HOLD_AT_WORD  = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = CAPACITY + 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [2:0] KIND_SPARE_5 = 3'd5;
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    typedef enum int {
        BURST_GROW,
        BURST_SHRINK,
        BURST_MIXED
    } t_burst;

    typedef struct {
        t_status            status;
        logic signed [31:0] data;
        logic [7:0]         found_position;
        logic [7:0]         count;
    } t_list_result;

    typedef struct {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [7:0]         position;
        bit                 fixed;
        t_list_result       want;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    olids_in_if  in_ch ();
    olids_out_if res_ch ();

    ordered_list_insert_delete_search_top #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    logic signed [31:0] shadow_entries [CAPACITY];
    int                 shadow_count;
    t_list_result       pending_results [$];

    int words_sent;
    int results_checked;
    int mismatches;
    int peak_count;
    int full_rejects;
    int status_seen [5];
    bit quiet_mode;
    bit hold_done;
    int hold_left;
    int stall_left;
    int cycle_count;

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{KIND_SEARCH,  32'sd0,          8'd0,   1'b1, '{ST_EMPTY,    32'sd0,          8'd0, 8'd0}},
        '{KIND_READ,    32'sd0,          8'd1,   1'b1, '{ST_EMPTY,    32'sd0,          8'd0, 8'd0}},
        '{KIND_DELETE,  32'sd0,          8'd255, 1'b1, '{ST_EMPTY,    32'sd0,          8'd0, 8'd0}},
        '{KIND_INSERT,  32'sd5,          8'd0,   1'b1, '{ST_BADPOS,   32'sd0,          8'd0, 8'd0}},
        '{KIND_INSERT,  32'sd5,          8'd2,   1'b1, '{ST_BADPOS,   32'sd0,          8'd0, 8'd0}},
        '{KIND_INSERT,  32'sh7FFF_FFFF,  8'd1,   1'b1, '{ST_OK,       32'sd0,          8'd0, 8'd1}},
        '{KIND_INSERT,  32'sh8000_0000,  8'd2,   1'b1, '{ST_OK,       32'sd0,          8'd0, 8'd2}},
        '{KIND_INSERT,  32'sd0,          8'd255, 1'b1, '{ST_BADPOS,   32'sd0,          8'd0, 8'd2}},
        '{KIND_READ,    32'sd0,          8'd1,   1'b1, '{ST_OK,       32'sh7FFF_FFFF,  8'd0, 8'd2}},
        '{KIND_READ,    32'sd0,          8'd2,   1'b1, '{ST_OK,       32'sh8000_0000,  8'd0, 8'd2}},
        '{KIND_READ,    32'sd0,          8'd3,   1'b1, '{ST_BADPOS,   32'sd0,          8'd0, 8'd2}},
        '{KIND_SEARCH,  32'sh8000_0000,  8'd0,   1'b1, '{ST_OK,       32'sd0,          8'd2, 8'd2}},
        '{KIND_SEARCH,  32'sd5,          8'd0,   1'b1, '{ST_NOTFOUND, 32'sd0,          8'd0, 8'd2}},
        '{KIND_INSERT,  32'shFFFF_FFFF,  8'd1,   1'b0, '{ST_OK,       32'sd0,          8'd0, 8'd0}},
        '{KIND_INSERT,  32'sh8000_0000,  8'd3,   1'b0, '{ST_OK,       32'sd0,          8'd0, 8'd0}},
        '{KIND_SEARCH,  32'sh8000_0000,  8'd0,   1'b0, '{ST_OK,       32'sd0,          8'd0, 8'd0}},
        '{KIND_SPARE_5, 32'shFFFF_FFFF,  8'd255, 1'b0, '{ST_OK,       32'sd0,          8'd0, 8'd0}},
        '{KIND_SPARE_7, 32'sd0,          8'd0,   1'b0, '{ST_OK,       32'sd0,          8'd0, 8'd0}},
        '{KIND_DELETE,  32'sd0,          8'd0,   1'b0, '{ST_OK,       32'sd0,          8'd0, 8'd0}},
        '{KIND_DELETE,  32'sd0,          8'd2,   1'b0, '{ST_OK,       32'sd0,          8'd0, 8'd0}},
        '{KIND_READ,    32'sd0,          8'd3,   1'b0, '{ST_OK,       32'sd0,          8'd0, 8'd0}},
        '{KIND_SPARE_6, 32'sh5555_AAAA,  8'd1,   1'b0, '{ST_OK,       32'sd0,          8'd0, 8'd0}},
        '{KIND_CLEAR,   32'shFFFF_FFFF,  8'd255, 1'b1, '{ST_OK,       32'sd0,          8'd0, 8'd0}},
        '{KIND_READ,    32'sd0,          8'd0,   1'b1, '{ST_EMPTY,    32'sd0,          8'd0, 8'd0}},
        '{KIND_INSERT,  32'sd12345,      8'd1,   1'b1, '{ST_OK,       32'sd0,          8'd0, 8'd1}}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_list_result apply_list_request(input logic [2:0] kind,
                                                        input logic signed [31:0] value,
                                                        input logic [7:0] position);
        t_list_result r;
        int           p;
        int           i;
        r.status         = ST_OK;
        r.data           = '0;
        r.found_position = '0;
        p                = int'(position);
        case (kind)
            KIND_CLEAR: begin
                shadow_count = 0;
            end
            KIND_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (p < 1 || p > shadow_count + 1) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (i = shadow_count; i >= p; i--)
                        shadow_entries[i] = shadow_entries[i - 1];
                    shadow_entries[p - 1] = value;
                    shadow_count++;
                end
            end
            KIND_DELETE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (p < 1 || p > shadow_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.data = shadow_entries[p - 1];
                    for (i = p - 1; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_count--;
                end
            end
            KIND_SEARCH: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_NOTFOUND;
                    for (i = 0; i < shadow_count; i++) begin
                        if (shadow_entries[i] == value) begin
                            r.found_position = 8'(i + 1);
                            r.status         = ST_OK;
                            break;
                        end
                    end
                end
            end
            KIND_READ: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (p < 1 || p > shadow_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.data = shadow_entries[p - 1];
                end
            end
            default: begin
            end
        endcase
        r.count = shadow_count[7:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3, 4: return $signed($urandom_range(0, 7)) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_position(input logic [2:0] kind);
        int top;
        int r;
        top = (kind == KIND_INSERT) ? shadow_count + 1 : shadow_count;
        r   = $urandom_range(0, 99);
        if (top > 0 && r < 85)
            return 8'($urandom_range(1, top));
        if (r < 92)
            return 8'd0;
        if (r < 97 && top < 255)
            return 8'($urandom_range(top + 1, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic offer_word(input logic [2:0] kind, input logic signed [31:0] value,
                              input logic [7:0] position, input bit fixed,
                              input t_list_result want);
        int           gap;
        t_list_result predicted;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= kind;
        in_ch.value    <= value;
        in_ch.position <= position;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predicted = apply_list_request(kind, value, position);
        pending_results.push_back(fixed ? want : predicted);
        words_sent++;
        status_seen[predicted.status]++;
        if (predicted.status == ST_FULL)
            full_rejects++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
    endtask

    task automatic issue_random(input t_burst mode);
        int                 w_ins;
        int                 w_del;
        int                 w_srch;
        int                 w_rd;
        int                 w_spare;
        int                 r;
        logic [2:0]         kind;
        logic signed [31:0] value;
        t_list_result       unused_want;
        unused_want = '{ST_OK, 32'sd0, 8'd0, 8'd0};
        case (mode)
            BURST_GROW: begin
                w_ins = 70; w_del = 5;  w_srch = 12; w_rd = 10; w_spare = 3;
            end
            BURST_SHRINK: begin
                w_ins = 15; w_del = 55; w_srch = 12; w_rd = 15; w_spare = 3;
            end
            default: begin
                w_ins = 35; w_del = 25; w_srch = 20; w_rd = 14; w_spare = 4;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < w_ins)
            kind = KIND_INSERT;
        else if (r < w_ins + w_del)
            kind = KIND_DELETE;
        else if (r < w_ins + w_del + w_srch)
            kind = KIND_SEARCH;
        else if (r < w_ins + w_del + w_srch + w_rd)
            kind = KIND_READ;
        else if (r < w_ins + w_del + w_srch + w_rd + w_spare)
            kind = 3'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
        else
            kind = KIND_CLEAR;
        if (kind == KIND_SEARCH && shadow_count > 0 && $urandom_range(0, 9) < 7)
            value = shadow_entries[$urandom_range(0, shadow_count - 1)];
        else
            value = pick_value();
        offer_word(kind, value, pick_position(kind), 1'b0, unused_want);
    endtask

    task automatic check_result();
        t_list_result want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected result word: status %0d data %0d pos %0d count %0d",
                         res_ch.status, res_ch.data, res_ch.found_position, res_ch.count);
        end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (res_ch.status !== want.status || res_ch.data !== want.data ||
                res_ch.found_position !== want.found_position || res_ch.count !== want.count)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("#%0d st/data/pos/cnt want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             results_checked, want.status, want.data, want.found_position,
                             want.count, res_ch.status, res_ch.data, res_ch.found_position,
                             res_ch.count);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                check_result();
            if (!hold_done && words_sent >= HOLD_AT_WORD) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        t_burst       mode;
        int           burst_len;
        int           row;
        t_list_result unused_want;
        in_ch.valid    = 1'b0;
        in_ch.kind     = KIND_CLEAR;
        in_ch.value    = '0;
        in_ch.position = '0;
        i_rst_n        = 1'b0;
        shadow_count   = 0;
        unused_want    = '{ST_OK, 32'sd0, 8'd0, 8'd0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < DIRECTED_ROWS; row++)
            offer_word(directed_rows[row].kind, directed_rows[row].value,
                       directed_rows[row].position, directed_rows[row].fixed,
                       directed_rows[row].want);

        // fill to capacity, then knock on the full list
        while (shadow_count < CAPACITY)
            offer_word(KIND_INSERT, pick_value(), 8'($urandom_range(1, shadow_count + 1)),
                       1'b0, unused_want);
        repeat (4)
            offer_word(KIND_INSERT, pick_value(), 8'($urandom_range(0, 255)), 1'b0,
                       unused_want);

        while (words_sent < DIRECTED_ROWS + RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mode = BURST_GROW;
                4, 5:       mode = BURST_SHRINK;
                default:    mode = BURST_MIXED;
            endcase
            quiet_mode = ($urandom_range(0, 4) == 0);
            burst_len  = $urandom_range(10, 80);
            repeat (burst_len) issue_random(mode);
        end
        quiet_mode  = 1'b0;
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d request words, %0d results scored, list depth peaked at %0d of %0d",
                 words_sent, results_checked, peak_count, CAPACITY);
        $display("status mix: ok %0d full %0d empty %0d bad position %0d not found %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_BADPOS], status_seen[ST_NOTFOUND]);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d bad result words", mismatches);
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
src/olids_pkg.sv
src/olids_if.sv
src/olids_front.sv
src/olids_queue.sv
src/olids_back.sv
src/ordered_list_insert_delete_search_top.sv
verif/ordered_list_insert_delete_search_top_test.sv
